// ===== sv/assert_macros.svh =====
// assertion macros shared by the complex arithmetic unit files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cau assertion failed");

// next-cycle implication, checked outside reset
`define CAU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cau assertion failed");

`endif

// ===== sv/cau_pkg.sv =====
// shared constants and types of the complex arithmetic unit
package cau_pkg;

  localparam int FRAC_BITS = 16;
  localparam int OP_W      = 3;
  localparam int DATA_W    = 32;
  localparam int SPLIT_W   = DATA_W;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = DATA_W + 1;
  localparam int PP_W      = PROD_W + 1;
  localparam int SQ_W      = 2 * SUM_W;
  localparam int D_W       = SQ_W;
  localparam int PAR_W     = PP_W + SUM_W;
  localparam int DIVN_W    = PP_W + FRAC_BITS + 1;
  localparam int NUM_W     = (DIVN_W > PAR_W) ? DIVN_W : PAR_W;
  localparam int MAG_W     = NUM_W - 1;
  localparam int QB        = DATA_W + 2;
  localparam int CMP_W     = D_W + QB - 1;
  localparam int DIR_W     = PP_W;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_PAR = 3'd4
  } op_t;

  // word travelling down the divider chain
  typedef struct packed {
    logic                     dz;
    logic                     use_div;
    logic                     neg_r;
    logic                     neg_i;
    logic [CMP_W-1:0]         dsh;
    logic [MAG_W-1:0]         rem_r;
    logic [MAG_W-1:0]         rem_i;
    logic [QB-1:0]            q_r;
    logic [QB-1:0]            q_i;
    logic signed [DIR_W-1:0]  dir_r;
    logic signed [DIR_W-1:0]  dir_i;
  } div_word_t;

endpackage

// ===== sv/cau_in_if.sv =====
// operand channel of the complex arithmetic unit
interface cau_in_if;
  import cau_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] a_real;
  logic signed [DATA_W-1:0] a_imag;
  logic signed [DATA_W-1:0] b_real;
  logic signed [DATA_W-1:0] b_imag;

  modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// ===== sv/cau_out_if.sv =====
// result channel of the complex arithmetic unit
interface cau_out_if;
  import cau_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_real;
  logic signed [DATA_W-1:0] result_imag;
  logic                     divided_by_zero;
  logic                     saturated;

  modport source (output valid, result_real, result_imag, divided_by_zero, saturated,
                  input ready);
  modport sink   (input valid, result_real, result_imag, divided_by_zero, saturated,
                  output ready);
endinterface

// ===== sv/cau_front.sv =====
// front pipeline: products, sums of squares and numerators ahead of the divider chain
`include "assert_macros.svh"

module cau_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cau_pkg::OP_W-1:0]          operation,
  input  logic signed [cau_pkg::DATA_W-1:0] a_real,
  input  logic signed [cau_pkg::DATA_W-1:0] a_imag,
  input  logic signed [cau_pkg::DATA_W-1:0] b_real,
  input  logic signed [cau_pkg::DATA_W-1:0] b_imag,
  output logic                              v_o,
  output cau_pkg::div_word_t                w_o
);
  import cau_pkg::*;

  function automatic logic signed [NUM_W-1:0] join_pp(input logic signed [SQ_W-1:0] hi,
                                                      input logic signed [SQ_W-1:0] lo);
    logic signed [NUM_W-1:0] hx;
    hx = NUM_W'(hi);
    join_pp = (hx <<< SPLIT_W) + NUM_W'(lo);
  endfunction

  // stage 0
  logic                     v0_r;
  op_t                      op0_r;
  logic signed [PROD_W-1:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [SUM_W-1:0]  lr0_r, li0_r, xr0_r, xi0_r;
  op_t                      op_in;
  logic signed [SUM_W-1:0]  sum_r, sum_i, lin_r, lin_i, x_r, x_i;

  // stage 1
  logic                     v1_r, dz1_r;
  op_t                      op1_r;
  logic signed [PP_W-1:0]   pr1_r, pi1_r, dnr1_r, dni1_r;
  logic signed [SQ_W-1:0]   sqa1_r, sqb1_r;
  logic signed [SUM_W-1:0]  xr1_r, xi1_r;
  logic signed [DIR_W-1:0]  dr1_r, di1_r;
  logic signed [PP_W-1:0]   pr_nxt, pi_nxt;
  logic signed [DIR_W-1:0]  dr_nxt, di_nxt;

  // stage 2
  logic                     v2_r, dz2_r;
  op_t                      op2_r;
  logic signed [DIR_W-1:0]  dr2_r, di2_r;
  logic [D_W-1:0]           d2_r;
  logic signed [SQ_W-1:0]   ah2_r, al2_r, bh2_r, bl2_r, ch2_r, cl2_r, eh2_r, el2_r;
  logic signed [PP_W-1:0]   dnr2_r, dni2_r;
  logic signed [SUM_W-1:0]  prh, prl, pih, pil;

  // stage 3
  logic                     v3_r, dz3_r;
  op_t                      op3_r;
  logic signed [DIR_W-1:0]  dr3_r, di3_r;
  logic [D_W-1:0]           d3_r;
  logic signed [NUM_W-1:0]  nr3_r, ni3_r;
  logic signed [NUM_W-1:0]  nr_nxt, ni_nxt;

  // stage 4
  logic                     v4_r;
  div_word_t                w4_r;
  logic [NUM_W-1:0]         mag_r, mag_i;

  assign in_ready = adv || !v0_r;

  always_comb begin
    op_in = op_t'(operation);
    sum_r = SUM_W'(a_real) + SUM_W'(b_real);
    sum_i = SUM_W'(a_imag) + SUM_W'(b_imag);
    lin_r = (op_in == OP_SUB) ? SUM_W'(a_real) - SUM_W'(b_real) : sum_r;
    lin_i = (op_in == OP_SUB) ? SUM_W'(a_imag) - SUM_W'(b_imag) : sum_i;
    // squares come from b for divide and from a+b for parallel
    x_r   = (op_in == OP_DIV) ? SUM_W'(b_real) : sum_r;
    x_i   = (op_in == OP_DIV) ? SUM_W'(b_imag) : sum_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_ready) begin
      v0_r <= in_valid;
    end
    if (in_ready) begin
      op0_r <= op_in;
      p1_r  <= a_real * b_real;
      p2_r  <= a_imag * b_imag;
      p3_r  <= a_real * b_imag;
      p4_r  <= a_imag * b_real;
      lr0_r <= lin_r;
      li0_r <= lin_i;
      xr0_r <= x_r;
      xi0_r <= x_i;
    end
  end

  always_comb begin
    pr_nxt = PP_W'(p1_r) - PP_W'(p2_r);
    pi_nxt = PP_W'(p3_r) + PP_W'(p4_r);
    case (op0_r)
      OP_ADD, OP_SUB: begin
        dr_nxt = DIR_W'(lr0_r);
        di_nxt = DIR_W'(li0_r);
      end
      OP_MUL: begin
        dr_nxt = pr_nxt >>> FRAC_BITS;
        di_nxt = pi_nxt >>> FRAC_BITS;
      end
      default: begin
        dr_nxt = '0;
        di_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
    if (adv) begin
      op1_r  <= op0_r;
      dz1_r  <= (op0_r == OP_DIV || op0_r == OP_PAR) && xr0_r == '0 && xi0_r == '0;
      pr1_r  <= pr_nxt;
      pi1_r  <= pi_nxt;
      dnr1_r <= PP_W'(p1_r) + PP_W'(p2_r);
      dni1_r <= PP_W'(p4_r) - PP_W'(p3_r);
      sqa1_r <= xr0_r * xr0_r;
      sqb1_r <= xi0_r * xi0_r;
      xr1_r  <= xr0_r;
      xi1_r  <= xi0_r;
      dr1_r  <= dr_nxt;
      di1_r  <= di_nxt;
    end
  end

  // split the exact products so each multiplier stays near 32 by 32
  always_comb begin
    prh = $signed(pr1_r[PP_W-1:SPLIT_W]);
    prl = $signed({1'b0, pr1_r[SPLIT_W-1:0]});
    pih = $signed(pi1_r[PP_W-1:SPLIT_W]);
    pil = $signed({1'b0, pi1_r[SPLIT_W-1:0]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
    if (adv) begin
      op2_r  <= op1_r;
      dz2_r  <= dz1_r;
      dr2_r  <= dr1_r;
      di2_r  <= di1_r;
      d2_r   <= sqa1_r + sqb1_r;
      ah2_r  <= prh * xr1_r;
      al2_r  <= prl * xr1_r;
      bh2_r  <= pih * xi1_r;
      bl2_r  <= pil * xi1_r;
      ch2_r  <= pih * xr1_r;
      cl2_r  <= pil * xr1_r;
      eh2_r  <= prh * xi1_r;
      el2_r  <= prl * xi1_r;
      dnr2_r <= dnr1_r;
      dni2_r <= dni1_r;
    end
  end

  always_comb begin
    if (op2_r == OP_PAR) begin
      nr_nxt = join_pp(ah2_r, al2_r) + join_pp(bh2_r, bl2_r);
      ni_nxt = join_pp(ch2_r, cl2_r) - join_pp(eh2_r, el2_r);
    end else begin
      nr_nxt = NUM_W'(dnr2_r) <<< FRAC_BITS;
      ni_nxt = NUM_W'(dni2_r) <<< FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
    if (adv) begin
      op3_r <= op2_r;
      dz3_r <= dz2_r;
      dr3_r <= dr2_r;
      di3_r <= di2_r;
      d3_r  <= d2_r;
      nr3_r <= nr_nxt;
      ni3_r <= ni_nxt;
    end
  end

  always_comb begin
    mag_r = nr3_r[NUM_W-1] ? -nr3_r : nr3_r;
    mag_i = ni3_r[NUM_W-1] ? -ni3_r : ni3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
    if (adv) begin
      w4_r.dz      <= dz3_r;
      w4_r.use_div <= (op3_r == OP_DIV || op3_r == OP_PAR);
      w4_r.neg_r   <= nr3_r[NUM_W-1];
      w4_r.neg_i   <= ni3_r[NUM_W-1];
      w4_r.dsh     <= CMP_W'(d3_r) << (QB - 1);
      w4_r.rem_r   <= mag_r[MAG_W-1:0];
      w4_r.rem_i   <= mag_i[MAG_W-1:0];
      w4_r.q_r     <= '0;
      w4_r.q_i     <= '0;
      w4_r.dir_r   <= dr3_r;
      w4_r.dir_i   <= di3_r;
    end
  end

  assign v_o = v4_r;
  assign w_o = w4_r;

  `CAU_ASSERT_NXT(a_accept_lands, clk, rst_n, in_valid && in_ready, v0_r)

endmodule

// ===== sv/cau_div_cell.sv =====
// one restoring divider cell: one quotient bit per lane, hands the word on each cycle while en is high
module cau_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  cau_pkg::div_word_t w_i,
  output logic               v_o,
  output cau_pkg::div_word_t w_o
);
  import cau_pkg::*;

  function automatic logic [MAG_W:0] lane_step(input logic [MAG_W-1:0] rem,
                                               input logic [CMP_W-1:0] dsh);
    logic [CMP_W:0] diff;
    diff = {1'b0, CMP_W'(rem)} - {1'b0, dsh};
    lane_step = diff[CMP_W] ? {1'b0, rem} : {1'b1, diff[MAG_W-1:0]};
  endfunction

  logic            v_r;
  div_word_t       w_r;
  div_word_t       w_nxt;
  logic [MAG_W:0]  sr, si;

  always_comb begin
    sr          = lane_step(w_i.rem_r, w_i.dsh);
    si          = lane_step(w_i.rem_i, w_i.dsh);
    w_nxt       = w_i;
    w_nxt.rem_r = sr[MAG_W-1:0];
    w_nxt.rem_i = si[MAG_W-1:0];
    w_nxt.q_r   = {w_i.q_r[QB-2:0], sr[MAG_W]};
    w_nxt.q_i   = {w_i.q_i[QB-2:0], si[MAG_W]};
    w_nxt.dsh   = w_i.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
    if (en) begin
      w_r <= w_nxt;
    end
  end

  assign v_o = v_r;
  assign w_o = w_r;

endmodule

// ===== sv/complex_arithmetic_unit.sv =====
// Complex arithmetic unit: add, subtract, multiply, divide and parallel combination
// a*b/(a+b) on signed Q16.16 complex operands, one result word per operand word.
// The unit is a fixed pipeline that takes a new word every clock while the output is not
// stalled. A result word passes through five front stages (products, squares, split partial
// products, numerator sums, magnitudes), a chain of 34 restoring divider cells that each
// settle one quotient bit of both parts, and the output register. A stalled output freezes
// the whole pipe. Every operation runs the same path, so results leave in order. A zero
// divisor returns the programmed bound value in both parts; results saturate to 32 bits.
`include "assert_macros.svh"

module complex_arithmetic_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  cau_in_if.sink                            in_chan,
  cau_out_if.source                         out_chan,
  input  logic                              cfg_we,
  input  logic signed [cau_pkg::DATA_W-1:0] cfg_wdata
);
  import cau_pkg::*;

  function automatic logic [DATA_W:0] sat_dir(input logic signed [DIR_W-1:0] x);
    if (x > DIR_W'(SAT_MAX)) begin
      sat_dir = {1'b1, SAT_MAX};
    end else if (x < DIR_W'(SAT_MIN)) begin
      sat_dir = {1'b1, SAT_MIN};
    end else begin
      sat_dir = {1'b0, x[DATA_W-1:0]};
    end
  endfunction

  function automatic logic [DATA_W:0] sat_quo(input logic [QB-1:0] q, input logic neg);
    logic              ovf;
    logic [DATA_W-1:0] mag;
    ovf = |q[QB-1:DATA_W];
    mag = q[DATA_W-1:0];
    if (neg) begin
      if (ovf || mag > SAT_MIN) begin
        sat_quo = {1'b1, SAT_MIN};
      end else begin
        sat_quo = {1'b0, -mag};
      end
    end else if (ovf || mag[DATA_W-1]) begin
      sat_quo = {1'b1, SAT_MAX};
    end else begin
      sat_quo = {1'b0, mag};
    end
  endfunction

  logic                     bound_r;
  logic signed [DATA_W-1:0] zero_bound_r;
  logic                     out_valid_r, out_dz_r, out_sat_r;
  logic signed [DATA_W-1:0] out_real_r, out_imag_r;
  logic                     adv, in_ready;
  logic                     cv [QB+1];
  div_word_t                cw [QB+1];
  div_word_t                wl;
  logic [DATA_W:0]          res_r, res_i;
  logic signed [DATA_W-1:0] real_nxt, imag_nxt;
  logic                     sat_nxt;
  logic                     out_dz_ok, out_clip;

  // the pipeline moves whenever the output register is free or being drained
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = in_ready;

  cau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .operation (in_chan.operation),
    .a_real    (in_chan.a_real),
    .a_imag    (in_chan.a_imag),
    .b_real    (in_chan.b_real),
    .b_imag    (in_chan.b_imag),
    .v_o       (cv[0]),
    .w_o       (cw[0])
  );

  for (genvar g = 0; g < QB; g++) begin : g_cell
    cau_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .v_i   (cv[g]),
      .w_i   (cw[g]),
      .v_o   (cv[g+1]),
      .w_o   (cw[g+1])
    );
  end

  always_comb begin
    wl = cw[QB];
    if (wl.use_div) begin
      res_r = sat_quo(wl.q_r, wl.neg_r);
      res_i = sat_quo(wl.q_i, wl.neg_i);
    end else begin
      res_r = sat_dir(wl.dir_r);
      res_i = sat_dir(wl.dir_i);
    end
    if (wl.dz) begin
      real_nxt = zero_bound_r;
      imag_nxt = zero_bound_r;
      sat_nxt  = 1'b0;
    end else begin
      real_nxt = res_r[DATA_W-1:0];
      imag_nxt = res_i[DATA_W-1:0];
      sat_nxt  = res_r[DATA_W] || res_i[DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r      <= 1'b0;
      zero_bound_r <= SAT_MAX;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        zero_bound_r <= cfg_wdata;
        bound_r      <= 1'b1;
      end
      if (adv) begin
        out_valid_r <= cv[QB];
      end
    end
    if (adv) begin
      out_real_r <= real_nxt;
      out_imag_r <= imag_nxt;
      out_dz_r   <= wl.dz;
      out_sat_r  <= sat_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.result_real     = out_real_r;
  assign out_chan.result_imag     = out_imag_r;
  assign out_chan.divided_by_zero = out_dz_r;
  assign out_chan.saturated       = out_sat_r;

  assign out_dz_ok = !out_sat_r && out_real_r == out_imag_r;
  assign out_clip  = out_real_r == SAT_MAX || out_real_r == SAT_MIN ||
                     out_imag_r == SAT_MAX || out_imag_r == SAT_MIN;

  // bound value stays at its reset value until the first write
  `CAU_ASSERT_IMP(a_bound_reset, clk, rst_n, !bound_r, zero_bound_r == SAT_MAX)
  `CAU_ASSERT_IMP(a_dz_word, clk, rst_n, out_valid_r && out_dz_r, out_dz_ok)
  `CAU_ASSERT_IMP(a_sat_clip, clk, rst_n, out_valid_r && out_sat_r, out_clip)

endmodule
